### design/single_wire_pulse_receiver_macros.svh
// assertion helpers for the pulse receiver
`ifndef SINGLE_WIRE_PULSE_RECEIVER_MACROS_SVH
`define SINGLE_WIRE_PULSE_RECEIVER_MACROS_SVH

// same-cycle implication
`define SWPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swpr assertion failed");

// next-cycle implication
`define SWPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swpr assertion failed");

`endif

### design/swpr_pkg.sv
package swpr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_FALL,
    PH_WAIT_RISE,
    PH_ZERO_WINDOW,
    PH_ZERO_RISE
  } phase_e;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TIMEOUT      = 3'd1;
  localparam logic [2:0] ST_FAIL         = 3'd2;
  localparam logic [2:0] ST_INVALID_SIZE = 3'd3;
  localparam logic [2:0] ST_SMALL_BUFFER = 3'd4;

  localparam int unsigned AddrW = 4;

  localparam logic [1:0] REG_START_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_ZERO_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_MIN_LENGTH    = 2'd2;

  localparam logic [15:0] START_TIMEOUT_RST = 16'd256;
  localparam logic [15:0] ZERO_TIMEOUT_RST  = 16'd64;
  localparam logic [7:0]  MIN_LENGTH_RST    = 8'd4;

  typedef struct packed {
    logic       opcode;
    logic       line_level;
    logic [7:0] capacity;
  } in_req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [2:0] status;
    logic       last;
  } out_req_t;

  typedef struct packed {
    logic [15:0] start_timeout;
    logic [15:0] zero_timeout;
    logic [7:0]  min_length;
  } cfg_t;

endpackage

### design/swpr_cfg_regs.sv
module swpr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [swpr_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output swpr_pkg::cfg_t               cfg_o
);

  swpr_pkg::cfg_t cfg_q;
  logic [1:0]     idx;
  logic           wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_timeout <= swpr_pkg::START_TIMEOUT_RST;
      cfg_q.zero_timeout  <= swpr_pkg::ZERO_TIMEOUT_RST;
      cfg_q.min_length    <= swpr_pkg::MIN_LENGTH_RST;
    end else if (wr_en) begin
      unique case (idx)
        swpr_pkg::REG_START_TIMEOUT: cfg_q.start_timeout <= pwdata[15:0];
        swpr_pkg::REG_ZERO_TIMEOUT:  cfg_q.zero_timeout  <= pwdata[15:0];
        swpr_pkg::REG_MIN_LENGTH:    cfg_q.min_length    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      swpr_pkg::REG_START_TIMEOUT: prdata = {16'd0, cfg_q.start_timeout};
      swpr_pkg::REG_ZERO_TIMEOUT:  prdata = {16'd0, cfg_q.zero_timeout};
      swpr_pkg::REG_MIN_LENGTH:    prdata = {24'd0, cfg_q.min_length};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

### design/swpr_decoder.sv
module swpr_decoder #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  swpr_pkg::in_req_t  item_i,
  input  swpr_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output swpr_pkg::out_req_t res_o
);

  localparam int unsigned CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  function automatic logic [CmpW-1:0] limit_of(input logic [15:0] r);
    logic [CmpW-1:0] lim;
    logic [CmpW-1:0] top;
    top = CmpW'({TIMER_BITS{1'b1}});
    lim = (r == 16'd0) ? CmpW'(1) : CmpW'(r);
    return (lim > top) ? top : lim;
  endfunction

  swpr_pkg::phase_e      phase_q, phase_d;
  logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [2:0]            pos_q, pos_d;
  logic [7:0]            shift_q, shift_d;
  logic [7:0]            idx_q, idx_d;
  logic [7:0]            total_q, total_d;

  logic       tick, high;
  logic       miss_start, miss_zero;
  logic       fin_one, fin_zero, fin, byte_done;
  logic [7:0] new_shift, total_eff, idx_inc;
  logic       first, bad_min, bad_cap, xfer_end, t_out;

  // shared decode of the current tick
  always_comb begin
    tick       = (item_i.opcode == swpr_pkg::OP_TICK);
    high       = item_i.line_level;
    cnt_inc    = (cnt_q == {TIMER_BITS{1'b1}}) ? cnt_q : cnt_q + TIMER_BITS'(1);
    miss_start = CmpW'(cnt_inc) >= limit_of(cfg_i.start_timeout);
    miss_zero  = CmpW'(cnt_inc) >= limit_of(cfg_i.zero_timeout);
    fin_one    = tick && (phase_q == swpr_pkg::PH_ZERO_WINDOW) && high && miss_zero;
    fin_zero   = tick && (phase_q == swpr_pkg::PH_ZERO_RISE) && (high || miss_zero);
    fin        = fin_one || fin_zero;
    new_shift  = shift_q | (8'(fin_one) << pos_q);
    byte_done  = fin && (pos_q == 3'd7);
    first      = (idx_q == 8'd0);
    bad_min    = first && (new_shift < cfg_i.min_length);
    bad_cap    = first && !bad_min && (new_shift > total_q);
    total_eff  = first ? new_shift : total_q;
    idx_inc    = idx_q + 8'd1;
    xfer_end   = idx_inc >= total_eff;
    t_out      = tick && miss_start &&
                 (((phase_q == swpr_pkg::PH_WAIT_FALL) && high) ||
                  ((phase_q == swpr_pkg::PH_WAIT_RISE) && !high));
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    idx_d   = idx_q;
    total_d = total_q;
    if (step_i) begin
      if (!tick) begin
        cnt_d   = '0;
        pos_d   = 3'd0;
        shift_d = 8'd0;
        idx_d   = 8'd0;
        total_d = item_i.capacity;
        phase_d = (item_i.capacity == 8'd0) ? swpr_pkg::PH_IDLE : swpr_pkg::PH_WAIT_FALL;
      end else begin
        unique case (phase_q)
          swpr_pkg::PH_IDLE: ;
          swpr_pkg::PH_WAIT_FALL: begin
            if (!high) begin
              cnt_d   = '0;
              phase_d = swpr_pkg::PH_WAIT_RISE;
            end else begin
              cnt_d = cnt_inc;
              if (t_out) phase_d = swpr_pkg::PH_IDLE;
            end
          end
          swpr_pkg::PH_WAIT_RISE: begin
            if (high) begin
              cnt_d   = '0;
              phase_d = swpr_pkg::PH_ZERO_WINDOW;
            end else begin
              cnt_d = cnt_inc;
              if (t_out) phase_d = swpr_pkg::PH_IDLE;
            end
          end
          swpr_pkg::PH_ZERO_WINDOW: begin
            if (!high) begin
              cnt_d   = '0;
              phase_d = swpr_pkg::PH_ZERO_RISE;
            end else begin
              cnt_d = cnt_inc;
            end
          end
          swpr_pkg::PH_ZERO_RISE: begin
            if (!high) cnt_d = cnt_inc;
          end
          default: phase_d = swpr_pkg::PH_IDLE;
        endcase
        // bit decided
        if (fin) begin
          cnt_d   = '0;
          phase_d = swpr_pkg::PH_WAIT_FALL;
          if (!byte_done) begin
            pos_d   = pos_q + 3'd1;
            shift_d = new_shift;
          end else begin
            pos_d   = 3'd0;
            shift_d = 8'd0;
            if (bad_min || bad_cap) begin
              phase_d = swpr_pkg::PH_IDLE;
            end else begin
              total_d = total_eff;
              idx_d   = idx_inc;
              if (xfer_end) phase_d = swpr_pkg::PH_IDLE;
            end
          end
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (!tick) begin
        res_valid_o  = (item_i.capacity == 8'd0);
        res_o.status = swpr_pkg::ST_OK;
        res_o.last   = 1'b1;
      end else if (t_out) begin
        res_valid_o  = 1'b1;
        res_o.status = first ? swpr_pkg::ST_TIMEOUT : swpr_pkg::ST_FAIL;
        res_o.last   = 1'b1;
      end else if (byte_done) begin
        res_valid_o      = 1'b1;
        res_o.data_byte  = new_shift;
        res_o.byte_valid = 1'b1;
        if (bad_min) begin
          res_o.status = swpr_pkg::ST_INVALID_SIZE;
        end else if (bad_cap) begin
          res_o.status = swpr_pkg::ST_SMALL_BUFFER;
        end else begin
          res_o.status = swpr_pkg::ST_OK;
        end
        res_o.last = bad_min || bad_cap || xfer_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= swpr_pkg::PH_IDLE;
      cnt_q   <= '0;
      pos_q   <= 3'd0;
      shift_q <= 8'd0;
      idx_q   <= 8'd0;
      total_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      idx_q   <= idx_d;
      total_q <= total_d;
    end
  end

endmodule

### design/single_wire_pulse_receiver.sv
// an accepted request is held in the input register; its result is registered into the output register
// throughput: one request per cycle while the output is not stalled, set by the single decode stage
// a stalled result holds the request behind it in the input register
// requests that end nothing pass through without a result
// reset: async active low; receiver idle, config registers at their defaults
module single_wire_pulse_receiver #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  swpr_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output swpr_pkg::out_req_t          out_req_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swpr_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  `include "single_wire_pulse_receiver_macros.svh"

  logic               in_valid_q;
  swpr_pkg::in_req_t  in_req_q;
  logic               out_valid_q;
  swpr_pkg::out_req_t out_req_q;
  logic               advance, step, res_valid;
  swpr_pkg::out_req_t res;
  swpr_pkg::cfg_t     cfg;

  assign advance     = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && advance;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  swpr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swpr_decoder #(
    .TIMER_BITS (TIMER_BITS)
  ) u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_req_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_req_q <= in_req_i;
    if (step && res_valid) out_req_q <= res;
  end

  `SWPR_ASSERT_NOW(a_status_only_at_end, clk_i, rst_ni,
    out_valid_o && !out_req_o.last, out_req_o.status == swpr_pkg::ST_OK)
  `SWPR_ASSERT_NOW(a_result_has_content, clk_i, rst_ni,
    out_valid_o, out_req_o.byte_valid || out_req_o.last)
  `SWPR_ASSERT_NOW(a_length_error_has_byte, clk_i, rst_ni,
    out_valid_o && (out_req_o.status == swpr_pkg::ST_INVALID_SIZE ||
                    out_req_o.status == swpr_pkg::ST_SMALL_BUFFER),
    out_req_o.byte_valid)
  `SWPR_ASSERT_NEXT(a_result_follows_step, clk_i, rst_ni,
    step && res_valid, out_valid_o)

endmodule
